// File: design/ecl_pkg.sv
// ----------------------------------------------------------------------------
// ecl_pkg
// Types, constants and replacement helpers for the eight-way cache lookup.
// ----------------------------------------------------------------------------
package ecl_pkg;

    localparam int WAYS      = 8;
    localparam int WAY_BITS  = 3;
    localparam int ADDR_W    = 64;
    localparam int TAG_LSB   = 14;
    localparam int TAG_W     = 50;
    localparam int STACK_W   = 24;
    localparam int TREE_W    = 7;
    localparam int LFSR_W    = 16;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

    localparam logic [1:0] POL_STACK  = 2'd0;
    localparam logic [1:0] POL_TREE   = 2'd1;
    localparam logic [1:0] POL_RANDOM = 2'd2;

    localparam logic [1:0] CFG_POLICY     = 2'd0;
    localparam logic [1:0] CFG_WRITE_BACK = 2'd1;
    localparam logic [1:0] CFG_WRITE_ALLOC = 2'd2;

    localparam logic FUNC_WRITE = 1'b1;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic                hit;
        logic [WAY_BITS-1:0] way;
        logic                allocated;
        logic                dirty_victim;
    } rsp_t;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
    } line_t;

    typedef struct packed {
        line_t [WAYS-1:0]   lines;
        logic [STACK_W-1:0] stack;
        logic [TREE_W-1:0]  tree;
    } set_row_t;

    localparam int ROW_W = $bits(set_row_t);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic lookup_rd;
        logic commit;
    } ctl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } ctl_sts_t;

    function automatic logic [STACK_W-1:0] stack_touch(input logic [STACK_W-1:0] s,
                                                       input logic [WAY_BITS-1:0] k);
        logic [STACK_W-1:0] r;
        logic               found;
        r     = s;
        found = 1'b0;
        for (int i = 0; i < WAYS; i++) begin
            if (!found && s[WAY_BITS*i +: WAY_BITS] == k) begin
                found = 1'b1;
                for (int m = 1; m < WAYS; m++) begin
                    if (m <= i)
                        r[WAY_BITS*m +: WAY_BITS] = s[WAY_BITS*(m-1) +: WAY_BITS];
                end
                r[WAY_BITS-1:0] = k;
            end
        end
        return r;
    endfunction

    function automatic logic [STACK_W-1:0] stack_push(input logic [STACK_W-1:0] s,
                                                      input logic [WAY_BITS-1:0] k);
        return {s[STACK_W-WAY_BITS-1:0], k};
    endfunction

    function automatic logic [TREE_W-1:0] tree_touch(input logic [TREE_W-1:0] c,
                                                     input logic [WAY_BITS-1:0] k);
        logic [TREE_W-1:0] r;
        unique case (k)
            3'd0:    r = c | 7'h0B;
            3'd1:    r = (c & 7'h77) | 7'h03;
            3'd2:    r = (c & 7'h7D) | 7'h11;
            3'd3:    r = (c & 7'h6D) | 7'h01;
            3'd4:    r = (c & 7'h7E) | 7'h24;
            3'd5:    r = (c & 7'h5E) | 7'h04;
            3'd6:    r = (c & 7'h7A) | 7'h40;
            default: r = c & 7'h3A;
        endcase
        return r;
    endfunction

    function automatic logic [WAY_BITS-1:0] tree_victim(input logic [TREE_W-1:0] c);
        logic [WAY_BITS-1:0] v;
        if (!c[0]) begin
            if (!c[1])
                v = c[3] ? 3'd1 : 3'd0;
            else
                v = c[4] ? 3'd3 : 3'd2;
        end else begin
            if (!c[2])
                v = c[5] ? 3'd5 : 3'd4;
            else
                v = c[6] ? 3'd7 : 3'd6;
        end
        return v;
    endfunction

    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
        return s[0] ? ((s >> 1) ^ LFSR_TAPS) : (s >> 1);
    endfunction

endpackage

// File: design/ecl_ram.sv
// ----------------------------------------------------------------------------
// ecl_ram
// Generic simple dual-port RAM with registered read.
// ----------------------------------------------------------------------------
module ecl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/ecl_ctrl.sv
// ----------------------------------------------------------------------------
// ecl_ctrl
// Controller: clearing pass, access acceptance and commit sequencing.
// ----------------------------------------------------------------------------
module ecl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ecl_pkg::ctl_sts_t sts,
    output ecl_pkg::ctl_cmd_t cmd
);
    import ecl_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (sts.clear_last) state_next = ST_IDLE;
            ST_IDLE:   if (in_valid) state_next = ST_UPDATE;
            ST_UPDATE: if (sts.out_free) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd.clear_wr  = (state_reg == ST_CLEAR);
        cmd.lookup_rd = (state_reg == ST_IDLE) && in_valid;
        cmd.commit    = (state_reg == ST_UPDATE) && sts.out_free;
        in_stall      = (state_reg != ST_IDLE);
    end

`ifndef NO_ASSERTIONS
    a_lookup_then_update: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lookup_rd |=> state_reg == ST_UPDATE)
        else $error("lookup not followed by update");
    a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (state_reg == ST_UPDATE) && sts.out_free)
        else $error("commit without output room");
    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_wr |-> in_stall && !cmd.lookup_rd)
        else $error("input taken during clearing pass");
`endif

endmodule

// File: design/ecl_datapath.sv
// ----------------------------------------------------------------------------
// ecl_datapath
// Set storage, tag match, victim selection, replacement update and output.
// ----------------------------------------------------------------------------
module ecl_datapath #(
    parameter int OFFSET_BITS = 3,
    parameter int SET_BITS    = 11
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ecl_pkg::req_t     in_data,
    output ecl_pkg::rsp_t     out_data,
    output logic              out_valid,
    input  logic              out_stall,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_index,
    input  logic [1:0]        cfg_data,
    input  ecl_pkg::ctl_cmd_t cmd,
    output ecl_pkg::ctl_sts_t sts
);
    import ecl_pkg::*;

    localparam int NUM_SETS = 1 << SET_BITS;

    req_t                req_reg;
    logic [1:0]          policy_reg;
    logic                wb_reg;
    logic                wa_reg;
    logic [LFSR_W-1:0]   lfsr_reg;
    logic [LFSR_W-1:0]   lfsr_next;
    logic [SET_BITS-1:0] clr_cnt_reg;
    logic                out_valid_reg;
    rsp_t                out_data_reg;

    logic [ROW_W-1:0]    rdata;
    set_row_t            row;
    set_row_t            row_next;
    logic [TAG_W-1:0]    tag;
    logic                hit;
    logic                free_found;
    logic                done;
    logic [WAY_BITS-1:0] hway;
    logic [WAY_BITS-1:0] fway;
    logic [WAY_BITS-1:0] full_victim;
    logic [WAY_BITS-1:0] victim;
    logic                make_dirty;
    logic                skip;
    logic [LFSR_W-1:0]   lfsr_stepped;
    rsp_t                rsp;

    logic                ram_we;
    logic [SET_BITS-1:0] ram_waddr;
    logic [ROW_W-1:0]    ram_wdata;

    ecl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_set_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.lookup_rd),
        .raddr (in_data.address[OFFSET_BITS +: SET_BITS]),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.lookup_rd)
            req_reg <= in_data;
        if (cmd.commit)
            out_data_reg <= rsp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= POL_TREE;
            wb_reg        <= 1'b1;
            wa_reg        <= 1'b0;
            lfsr_reg      <= LFSR_SEED;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_POLICY:      policy_reg <= cfg_data;
                    CFG_WRITE_BACK:  wb_reg     <= cfg_data[0];
                    CFG_WRITE_ALLOC: wa_reg     <= cfg_data[0];
                    default:         ;
                endcase
            end
            if (cmd.clear_wr)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.commit)
                lfsr_reg <= lfsr_next;
            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign row          = set_row_t'(rdata);
    assign tag          = req_reg.address[ADDR_W-1:TAG_LSB];
    assign make_dirty   = (req_reg.func == FUNC_WRITE) && wb_reg;
    assign lfsr_stepped = lfsr_step(lfsr_reg);

    // in-order way search: a hit or the first invalid way ends it
    always_comb
    begin
        done       = 1'b0;
        hit        = 1'b0;
        free_found = 1'b0;
        hway       = '0;
        fway       = '0;
        for (int j = 0; j < WAYS; j++) begin
            if (!done) begin
                if (row.lines[j].valid) begin
                    if (row.lines[j].tag == tag) begin
                        hit  = 1'b1;
                        hway = WAY_BITS'(j);
                        done = 1'b1;
                    end
                end else begin
                    free_found = 1'b1;
                    fway       = WAY_BITS'(j);
                    done       = 1'b1;
                end
            end
        end
    end

    assign skip = !hit && (req_reg.func == FUNC_WRITE) && !wa_reg;

    always_comb
    begin
        unique case (policy_reg)
            POL_STACK:  full_victim = row.stack[STACK_W-1 -: WAY_BITS];
            POL_TREE:   full_victim = tree_victim(row.tree);
            POL_RANDOM: full_victim = lfsr_stepped[WAY_BITS-1:0];
            default:    full_victim = '0;
        endcase
    end

    assign victim = free_found ? fway : full_victim;

    always_comb
    begin
        row_next  = row;
        lfsr_next = lfsr_reg;
        rsp       = '0;
        if (hit)
        begin
            if (make_dirty)
                row_next.lines[hway].dirty = 1'b1;
            if (policy_reg == POL_STACK)
                row_next.stack = stack_touch(row.stack, hway);
            else if (policy_reg == POL_TREE)
                row_next.tree = tree_touch(row.tree, hway);
            rsp.hit = 1'b1;
            rsp.way = hway;
        end
        else if (!skip)
        begin
            if (policy_reg == POL_STACK)
                row_next.stack = free_found ? stack_push(row.stack, victim)
                                            : stack_touch(row.stack, victim);
            else if (policy_reg == POL_TREE)
                row_next.tree = tree_touch(row.tree, victim);
            else if (policy_reg == POL_RANDOM && !free_found)
                lfsr_next = lfsr_stepped;
            rsp.dirty_victim = !free_found && row.lines[victim].dirty;
            row_next.lines[victim].valid = 1'b1;
            row_next.lines[victim].dirty = make_dirty;
            row_next.lines[victim].tag   = tag;
            rsp.way       = victim;
            rsp.allocated = 1'b1;
        end
    end

    assign ram_we    = cmd.clear_wr || (cmd.commit && !skip);
    assign ram_waddr = cmd.clear_wr ? clr_cnt_reg : req_reg.address[OFFSET_BITS +: SET_BITS];
    assign ram_wdata = cmd.clear_wr ? '0 : ROW_W'(row_next);

    assign sts.clear_last = &clr_cnt_reg;
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: design/eight_way_cache_lookup_replace.sv
// ----------------------------------------------------------------------------
// eight_way_cache_lookup_replace
// Eight-way set-associative lookup with stack, tree or random replacement.
// ----------------------------------------------------------------------------
// the set row and request are registered on acceptance, then the response on commit,
// which waits while out_stall holds the last result; a new access waits for that commit
// the controller takes one access at a time: read the set row, then write it back
// reset: a clearing pass writes every set row to zero, NUM_SETS rows (2048 by default)
// input stall stays high during the pass; configuration writes are taken at any time
module eight_way_cache_lookup_replace #(
    parameter int OFFSET_BITS = 3,
    parameter int CACHE_BYTES = 131072
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  ecl_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output ecl_pkg::rsp_t out_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [1:0]    cfg_data
);
    import ecl_pkg::*;

    localparam int SET_BITS = $clog2(CACHE_BYTES >> OFFSET_BITS) - WAY_BITS;

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    assign cfg_ready = 1'b1;

    ecl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ecl_datapath #(
        .OFFSET_BITS (OFFSET_BITS),
        .SET_BITS    (SET_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the eight-way cache lookup. A short stimulus table
// and randomized access streams over small set and tag pools are checked
// against a behavioral cache model, across all replacement policies, both
// write modes, varied handshake idling and a long output back-pressure hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import ecl_pkg::*;

    localparam int NSETS       = 2048;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic              func;
        logic [ADDR_W-1:0] address;
        bit                typed;
        rsp_t              rsp;
    } access_row_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_stall;
    req_t  in_data = '0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    rsp_t  out_data;
    logic  cfg_valid = 1'b0;
    logic  cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [1:0] cfg_data = '0;

    bit             m_valid [NSETS][WAYS];
    bit             m_dirty [NSETS][WAYS];
    logic [TAG_W-1:0] m_tag [NSETS][WAYS];
    logic [STACK_W-1:0] m_stack [NSETS];
    logic [TREE_W-1:0]  m_tree [NSETS];
    logic [LFSR_W-1:0]  m_lfsr;
    logic [1:0] m_policy;
    bit         m_wb;
    bit         m_walloc;

    rsp_t pending_rsp[$];
    int   errors = 0;
    int   cycles = 0;
    int   send_pct = 0;
    int   recv_pct = 0;
    bit   press_go = 1'b0;
    bit   press_done = 1'b0;
    int   press_left = 0;

    access_row_t dir_rows[$];
    logic [TAG_W-1:0] tag_pool[12];
    logic [10:0]      set_pool[4];

    eight_way_cache_lookup_replace dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] mk_addr(logic [TAG_W-1:0] t, logic [10:0] s,
                                                  logic [2:0] o);
        return {t, s, o};
    endfunction

    function automatic void touch_stack(int s, logic [WAY_BITS-1:0] k);
        logic [STACK_W-1:0] v;
        v = m_stack[s];
        for (int i = 0; i < WAYS; i++)
        begin
            if (v[3*i +: 3] == k)
            begin
                for (int m = i; m > 0; m--)
                    m_stack[s][3*m +: 3] = v[3*(m-1) +: 3];
                m_stack[s][2:0] = k;
                return;
            end
        end
    endfunction

    function automatic void touch_tree(int s, logic [WAY_BITS-1:0] k);
        logic [TREE_W-1:0] c;
        c = m_tree[s];
        case (k)
            3'd0: c = c | 7'h0B;
            3'd1: c = (c & 7'h77) | 7'h03;
            3'd2: c = (c & 7'h7D) | 7'h11;
            3'd3: c = (c & 7'h6D) | 7'h01;
            3'd4: c = (c & 7'h7E) | 7'h24;
            3'd5: c = (c & 7'h5E) | 7'h04;
            3'd6: c = (c & 7'h7A) | 7'h40;
            default: c = c & 7'h3A;
        endcase
        m_tree[s] = c;
    endfunction

    function automatic logic [WAY_BITS-1:0] pick_tree(int s);
        logic [TREE_W-1:0] c;
        c = m_tree[s];
        if (!c[0])
            return !c[1] ? {2'b00, c[3]} : {2'b01, c[4]};
        return !c[2] ? {2'b10, c[5]} : {2'b11, c[6]};
    endfunction

    function automatic rsp_t cache_access(req_t r);
        rsp_t             res;
        int               s;
        int               free_way;
        logic [TAG_W-1:0] t;
        logic [WAY_BITS-1:0] vic;
        bit               mk_dirty;
        res      = '0;
        s        = int'(r.address[13:3]);
        t        = r.address[63:14];
        mk_dirty = (r.func == FUNC_WRITE) && m_wb;
        free_way = -1;
        for (int j = 0; j < WAYS; j++)
        begin
            if (!m_valid[s][j])
            begin
                free_way = j;
                break;
            end
            if (m_tag[s][j] == t)
            begin
                if (mk_dirty)
                    m_dirty[s][j] = 1'b1;
                if (m_policy == POL_STACK)
                    touch_stack(s, WAY_BITS'(j));
                else if (m_policy == POL_TREE)
                    touch_tree(s, WAY_BITS'(j));
                res.hit = 1'b1;
                res.way = WAY_BITS'(j);
                return res;
            end
        end
        if (r.func == FUNC_WRITE && !m_walloc)
            return res;
        if (free_way >= 0)
        begin
            vic = WAY_BITS'(free_way);
            if (m_policy == POL_STACK)
                m_stack[s] = {m_stack[s][STACK_W-4:0], vic};
            else if (m_policy == POL_TREE)
                touch_tree(s, vic);
        end
        else
        begin
            if (m_policy == POL_STACK)
            begin
                vic = m_stack[s][23:21];
                touch_stack(s, vic);
            end
            else if (m_policy == POL_TREE)
            begin
                vic = pick_tree(s);
                touch_tree(s, vic);
            end
            else if (m_policy == POL_RANDOM)
            begin
                m_lfsr = m_lfsr[0] ? ((m_lfsr >> 1) ^ 16'hB400) : (m_lfsr >> 1);
                vic    = m_lfsr[2:0];
            end
            else
                vic = '0;
            res.dirty_victim = m_dirty[s][vic];
        end
        m_tag[s][vic]   = t;
        m_valid[s][vic] = 1'b1;
        m_dirty[s][vic] = mk_dirty;
        res.way         = vic;
        res.allocated   = 1'b1;
        return res;
    endfunction

    task automatic report(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // receiver: random stall plus one long hold
    always @(posedge clk)
    begin
        if (press_go && !press_done)
        begin
            press_left <= 300;
            press_done <= 1'b1;
        end
        else if (press_left != 0)
            press_left <= press_left - 1;
        out_stall <= (press_left > 1) || ($urandom_range(99) < recv_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rsp.size() == 0)
                report("unexpected transaction", 8'(out_data), 8'd0);
            else
            begin
                rsp_t e;
                e = pending_rsp.pop_front();
                if (out_data.hit !== e.hit)
                    report("hit", 8'(out_data.hit), 8'(e.hit));
                if (out_data.way !== e.way)
                    report("way", 8'(out_data.way), 8'(e.way));
                if (out_data.allocated !== e.allocated)
                    report("allocated", 8'(out_data.allocated), 8'(e.allocated));
                if (out_data.dirty_victim !== e.dirty_victim)
                    report("dirty_victim", 8'(out_data.dirty_victim), 8'(e.dirty_victim));
            end
        end
    end

    task automatic send(logic f, logic [ADDR_W-1:0] a, bit typed, rsp_t want);
        rsp_t p;
        in_valid <= 1'b1;
        in_data  <= '{func: f, address: a};
        do
            @(posedge clk);
        while (in_stall);
        p = cache_access('{func: f, address: a});
        pending_rsp = {pending_rsp, (typed ? want : p)};
        if ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_POLICY)
            m_policy = val;
        else if (idx == CFG_WRITE_BACK)
            m_wb = val[0];
        else if (idx == CFG_WRITE_ALLOC)
            m_walloc = val[0];
    endtask

    task automatic random_phase(logic [1:0] pol, logic [1:0] wb, logic [1:0] wa, int sp,
                                int rp, int n, bit press);
        logic [ADDR_W-1:0] a;
        settle();
        write_reg(CFG_POLICY, pol);
        write_reg(CFG_WRITE_BACK, wb);
        write_reg(CFG_WRITE_ALLOC, wa);
        send_pct = sp;
        recv_pct = rp;
        for (int i = 0; i < 12; i++)
            tag_pool[i] = TAG_W'({$urandom(), $urandom()});
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 0; i < 4; i++)
            set_pool[i] = 11'($urandom_range(NSETS - 1));
        for (int i = 0; i < n; i++)
        begin
            if (press && i == 20)
                press_go <= 1'b1;
            if ($urandom_range(9) == 0)
                a = {$urandom(), $urandom()};
            else
                a = mk_addr(tag_pool[$urandom_range(11)], set_pool[$urandom_range(3)],
                            3'($urandom_range(7)));
            send(1'($urandom_range(1)), a, 1'b0, '0);
        end
    endtask

    initial
    begin
        for (int s = 0; s < NSETS; s++)
        begin
            m_stack[s] = '0;
            m_tree[s]  = '0;
            for (int w = 0; w < WAYS; w++)
            begin
                m_valid[s][w] = 1'b0;
                m_dirty[s][w] = 1'b0;
                m_tag[s][w]   = '0;
            end
        end
        m_lfsr   = LFSR_SEED;
        m_policy = POL_TREE;
        m_wb     = 1'b1;
        m_walloc = 1'b0;

        dir_rows.push_back('{1'b0, '0, 1'b1, '{1'b0, 3'd0, 1'b1, 1'b0}});
        dir_rows.push_back('{1'b0, '0, 1'b1, '{1'b1, 3'd0, 1'b0, 1'b0}});
        dir_rows.push_back('{FUNC_WRITE, '1, 1'b1, '{1'b0, 3'd0, 1'b0, 1'b0}});
        dir_rows.push_back('{1'b0, '1, 1'b1, '{1'b0, 3'd0, 1'b1, 1'b0}});
        dir_rows.push_back('{FUNC_WRITE, '1, 1'b1, '{1'b1, 3'd0, 1'b0, 1'b0}});
        for (int t = 1; t <= 8; t++)
            dir_rows.push_back('{1'b0, mk_addr(TAG_W'(t), 11'h7FF, 3'd0), 1'b0, '0});
        dir_rows.push_back('{1'b0, '1, 1'b0, '0});
        for (int t = 5; t <= 7; t++)
            dir_rows.push_back('{FUNC_WRITE, mk_addr(TAG_W'(t), 11'h7FF, 3'd7), 1'b0, '0});
        for (int t = 9; t <= 14; t++)
            dir_rows.push_back('{1'b0, mk_addr(TAG_W'(t), 11'h7FF, 3'd3), 1'b0, '0});
        dir_rows.push_back('{1'b0, mk_addr({25{2'b10}}, 11'h555, 3'd5), 1'b0, '0});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_pct = 23;
        recv_pct = 62;
        foreach (dir_rows[i])
            send(dir_rows[i].func, dir_rows[i].address, dir_rows[i].typed, dir_rows[i].rsp);

        settle();
        write_reg(2'd3, 2'd3);
        random_phase(POL_STACK,  2'd1, 2'd1, 23, 62, 115, 1'b0);
        random_phase(POL_TREE,   2'd2, 2'd1, 23, 62, 115, 1'b1);
        random_phase(POL_RANDOM, 2'd1, 2'd0, 23, 62, 115, 1'b0);
        random_phase(2'd3,       2'd1, 2'd3, 62, 23, 115, 1'b0);
        random_phase(POL_RANDOM, 2'd0, 2'd1, 62, 23, 115, 1'b0);
        random_phase(POL_STACK,  2'd3, 2'd0, 62, 23, 115, 1'b0);
        random_phase(POL_TREE,   2'd1, 2'd1, 0, 0, 115, 1'b0);
        random_phase(POL_RANDOM, 2'd1, 2'd1, 0, 0, 115, 1'b0);
        settle();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
design/ecl_pkg.sv
design/ecl_ram.sv
design/ecl_ctrl.sv
design/ecl_datapath.sv
design/eight_way_cache_lookup_replace.sv
sim/tb_top.sv
